### hw/rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared codes and character constants for the semicolon-separated text
// tokenizer and its checker.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 3;

  typedef enum logic [KindW-1:0] {
    KIND_NONE = 3'd0,
    KIND_BYTE = 3'd1,
    KIND_FEND = 3'd2,
    KIND_REND = 3'd3,
    KIND_ERR  = 3'd4
  } kind_e;

  localparam logic [ByteW-1:0] ChSemi  = 8'h3B;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChQuote = 8'h22;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;

endpackage

### hw/rtl/csv_semicolon_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// csv_semicolon_tokenizer_unit
// Streaming tokenizer for semicolon-separated text, one byte per transfer.
// ----------------------------------------------------------------------------
// Every accepted byte gives exactly one result transfer, and while results are
// not stalled a new byte can be accepted in every cycle, so throughput is one
// byte per clock. A byte is held in an input register, goes through the
// parser's next-state and result decode against the parse state, and then
// lands in the result register, from which its result is offered. While a
// result is stalled one more byte can be taken into the input register before
// in_stall_o rises. The single parse-state register, updated once per byte, is
// the loop that sets this rate. Results are kinds: nothing, field byte, field
// end, record end or error; once an error is reported every later result is an
// error until reset. parse_ok_o is set on the last byte only when the text
// ended on a record boundary without error.
module csv_semicolon_tokenizer_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [cst_pkg::ByteW-1:0] in_byte_i,
  input  logic                     is_last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [cst_pkg::KindW-1:0] kind_o,
  output logic [cst_pkg::ByteW-1:0] field_byte_o,
  output logic                     input_done_o,
  output logic                     parse_ok_o
);

  typedef enum logic [2:0] {
    ST_REC    = 3'd0,
    ST_REC_CR = 3'd1,
    ST_FIELD  = 3'd2,
    ST_PLAIN  = 3'd3,
    ST_QUOTED = 3'd4,
    ST_QSEEN  = 3'd5,
    ST_TRAIL  = 3'd6,
    ST_ERR    = 3'd7
  } state_e;

  state_e                    state_q, state_d;
  logic                      in_vld_q;
  logic [cst_pkg::ByteW-1:0] byte_q;
  logic                      last_q;
  logic                      out_vld_q;
  cst_pkg::kind_e            kind_q, kind_d;
  logic [cst_pkg::ByteW-1:0] fbyte_q, fbyte_d;
  logic                      done_q;
  logic                      ok_q, ok_d;

  logic out_free;
  logic advance;
  logic in_fire;
  logic is_blank, is_quote, is_end;
  cst_pkg::kind_e end_kind;
  state_e         end_state;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign is_blank = (byte_q == cst_pkg::ChSpace) || (byte_q == cst_pkg::ChTab);
  assign is_quote = (byte_q == cst_pkg::ChQuote);
  assign is_end   = (byte_q == cst_pkg::ChSemi) || (byte_q == cst_pkg::ChCr) ||
                    (byte_q == cst_pkg::ChLf);

  // separator or line end
  always_comb begin
    end_kind  = cst_pkg::KIND_REND;
    end_state = ST_REC;
    if (byte_q == cst_pkg::ChSemi) begin
      end_kind  = cst_pkg::KIND_FEND;
      end_state = ST_FIELD;
    end else if (byte_q == cst_pkg::ChCr) begin
      end_state = ST_REC_CR;
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d  = cst_pkg::KIND_NONE;
    fbyte_d = '0;
    unique case (state_q) inside
      ST_REC, ST_REC_CR, ST_FIELD: begin
        if (state_q == ST_REC_CR && byte_q == cst_pkg::ChLf) begin
          state_d = ST_REC;
        end else if (is_blank) begin
          state_d = ST_FIELD;
        end else if (is_end) begin
          kind_d  = end_kind;
          state_d = end_state;
        end else if (is_quote) begin
          state_d = ST_QUOTED;
        end else begin
          kind_d  = cst_pkg::KIND_BYTE;
          fbyte_d = byte_q;
          state_d = ST_PLAIN;
        end
      end
      ST_PLAIN: begin
        if (is_blank) begin
          state_d = ST_TRAIL;
        end else if (is_end) begin
          kind_d  = end_kind;
          state_d = end_state;
        end else if (is_quote) begin
          kind_d  = cst_pkg::KIND_ERR;
          state_d = ST_ERR;
        end else begin
          kind_d  = cst_pkg::KIND_BYTE;
          fbyte_d = byte_q;
        end
      end
      ST_QUOTED: begin
        if (is_quote) begin
          state_d = ST_QSEEN;
        end else begin
          kind_d  = cst_pkg::KIND_BYTE;
          fbyte_d = byte_q;
        end
      end
      ST_QSEEN, ST_TRAIL: begin
        if (state_q == ST_QSEEN && is_quote) begin
          kind_d  = cst_pkg::KIND_BYTE;
          fbyte_d = byte_q;
          state_d = ST_QUOTED;
        end else if (is_blank) begin
          state_d = ST_TRAIL;
        end else if (is_end) begin
          kind_d  = end_kind;
          state_d = end_state;
        end else begin
          kind_d  = cst_pkg::KIND_ERR;
          state_d = ST_ERR;
        end
      end
      default: begin
        kind_d  = cst_pkg::KIND_ERR;
        state_d = ST_ERR;
      end
    endcase
    ok_d = last_q && (state_d == ST_REC || state_d == ST_REC_CR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_REC;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      kind_q    <= cst_pkg::KIND_NONE;
      fbyte_q   <= '0;
      done_q    <= 1'b0;
      ok_q      <= 1'b0;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
        kind_q    <= kind_d;
        fbyte_q   <= fbyte_d;
        done_q    <= last_q;
        ok_q      <= ok_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= in_byte_i;
      last_q <= is_last_i;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign kind_o       = kind_q;
  assign field_byte_o = fbyte_q;
  assign input_done_o = done_q;
  assign parse_ok_o   = ok_q;

endmodule

### hw/rtl/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks for the tokenizer, bound to its top level.
// ----------------------------------------------------------------------------
module cst_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [cst_pkg::ByteW-1:0] in_byte_i,
  input logic                      is_last_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [cst_pkg::KindW-1:0] kind_o,
  input logic [cst_pkg::ByteW-1:0] field_byte_o,
  input logic                      input_done_o,
  input logic                      parse_ok_o
);

  logic err_seen_q;
  logic [1:0] pend_q;
  logic unused_in;

  assign unused_in = ^{in_byte_i, is_last_i};

  // an error result has been handed over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i &&
                 kind_o == cst_pkg::KIND_ERR) begin
      err_seen_q <= 1'b1;
    end
  end

  // count of items accepted and not yet handed over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_valid_i && !in_stall_o)
                       - 2'(out_valid_o && !out_stall_i);
    end
  end

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != cst_pkg::KIND_BYTE |-> field_byte_o == '0)
    else $error("field byte set on a non-byte result");

  a_ok_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_ok_o |->
      input_done_o && (kind_o == cst_pkg::KIND_REND || kind_o == cst_pkg::KIND_NONE))
    else $error("parse ok off a record boundary");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && err_seen_q |-> kind_o == cst_pkg::KIND_ERR)
    else $error("result after an error is not an error");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result without an accepted byte");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(kind_o) && $stable(field_byte_o) && $stable(parse_ok_o))
    else $error("stalled result changed");

  logic unused_ok;
  assign unused_ok = unused_in;

endmodule

bind csv_semicolon_tokenizer_unit cst_checker u_cst_checker (.*);

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the semicolon-separated text tokenizer. A queue of
// text bytes feeds a clocked driver, every accepted byte runs through a local
// parser model, and a clocked monitor compares each result transfer in order.
// Random records with blanks, plain and quoted fields and all line-end forms
// form the bulk; the sticky error state is only entered at the very end.
// ----------------------------------------------------------------------------
module testbench;

  typedef enum logic [2:0] {
    PS_REC, PS_REC_CR, PS_FIELD, PS_PLAIN, PS_QUOTED, PS_QSEEN, PS_TRAIL, PS_ERR
  } parse_state_e;

  typedef struct packed {
    logic [cst_pkg::ByteW-1:0] ch;
    logic                      last;
  } text_item_t;

  typedef struct {
    cst_pkg::kind_e            kind;
    logic [cst_pkg::ByteW-1:0] fbyte;
    logic                      done;
    logic                      ok;
  } token_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic [cst_pkg::ByteW-1:0] in_byte_i   = '0;
  logic                      is_last_i   = 1'b0;
  logic                      out_stall_i = 1'b0;
  logic                      in_stall_o;
  logic                      out_valid_o;
  logic [cst_pkg::KindW-1:0] kind_o;
  logic [cst_pkg::ByteW-1:0] field_byte_o;
  logic                      input_done_o;
  logic                      parse_ok_o;

  text_item_t   text_q[$];
  token_t       token_q[$];
  parse_state_e tok_state = PS_REC;
  logic         in_taken  = 1'b0;
  logic         drained   = 1'b0;
  int unsigned  idle_pct  = 38;
  int unsigned  n_sent    = 0;
  int unsigned  n_errors  = 0;
  int unsigned  n_checked = 0;
  int unsigned  n_fbyte   = 0;
  int unsigned  n_fend    = 0;
  int unsigned  n_rend    = 0;
  int unsigned  n_err     = 0;
  int unsigned  n_clean   = 0;

  csv_semicolon_tokenizer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .field_byte_o(field_byte_o),
    .input_done_o(input_done_o),
    .parse_ok_o  (parse_ok_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic cst_pkg::kind_e close_field(input logic [cst_pkg::ByteW-1:0] c);
    cst_pkg::kind_e k;
    k = cst_pkg::KIND_NONE;
    if (c == cst_pkg::ChSemi) begin
      k = cst_pkg::KIND_FEND;
      tok_state = PS_FIELD;
    end else if (c == cst_pkg::ChCr) begin
      k = cst_pkg::KIND_REND;
      tok_state = PS_REC_CR;
    end else if (c == cst_pkg::ChLf) begin
      k = cst_pkg::KIND_REND;
      tok_state = PS_REC;
    end
    return k;
  endfunction

  function automatic token_t tokenize_step(input logic [cst_pkg::ByteW-1:0] c,
                                           input logic last);
    token_t         r;
    cst_pkg::kind_e k;
    logic           blank;
    r.kind  = cst_pkg::KIND_NONE;
    r.fbyte = '0;
    r.done  = last;
    r.ok    = 1'b0;
    blank   = (c == cst_pkg::ChSpace) || (c == cst_pkg::ChTab);
    case (tok_state) inside
      PS_REC, PS_REC_CR, PS_FIELD: begin
        if (tok_state == PS_REC_CR && c == cst_pkg::ChLf) begin
          tok_state = PS_REC;
        end else if (blank) begin
          tok_state = PS_FIELD;
        end else begin
          k = close_field(c);
          if (k != cst_pkg::KIND_NONE) begin
            r.kind = k;
          end else if (c == cst_pkg::ChQuote) begin
            tok_state = PS_QUOTED;
          end else begin
            r.kind    = cst_pkg::KIND_BYTE;
            r.fbyte   = c;
            tok_state = PS_PLAIN;
          end
        end
      end
      PS_PLAIN: begin
        if (blank) begin
          tok_state = PS_TRAIL;
        end else begin
          k = close_field(c);
          if (k != cst_pkg::KIND_NONE) begin
            r.kind = k;
          end else if (c == cst_pkg::ChQuote) begin
            r.kind    = cst_pkg::KIND_ERR;
            tok_state = PS_ERR;
          end else begin
            r.kind  = cst_pkg::KIND_BYTE;
            r.fbyte = c;
          end
        end
      end
      PS_QUOTED: begin
        if (c == cst_pkg::ChQuote) begin
          tok_state = PS_QSEEN;
        end else begin
          r.kind  = cst_pkg::KIND_BYTE;
          r.fbyte = c;
        end
      end
      PS_QSEEN, PS_TRAIL: begin
        if (tok_state == PS_QSEEN && c == cst_pkg::ChQuote) begin
          r.kind    = cst_pkg::KIND_BYTE;
          r.fbyte   = c;
          tok_state = PS_QUOTED;
        end else if (blank) begin
          tok_state = PS_TRAIL;
        end else begin
          k = close_field(c);
          if (k != cst_pkg::KIND_NONE) begin
            r.kind = k;
          end else begin
            r.kind    = cst_pkg::KIND_ERR;
            tok_state = PS_ERR;
          end
        end
      end
      default: begin
        r.kind    = cst_pkg::KIND_ERR;
        tok_state = PS_ERR;
      end
    endcase
    r.ok = last && (tok_state == PS_REC || tok_state == PS_REC_CR);
    return r;
  endfunction

  function automatic logic [cst_pkg::ByteW-1:0] plain_byte();
    logic [cst_pkg::ByteW-1:0] c;
    do begin
      c = cst_pkg::ByteW'($urandom_range(255, 0));
    end while (c == cst_pkg::ChSpace || c == cst_pkg::ChTab || c == cst_pkg::ChSemi ||
               c == cst_pkg::ChQuote || c == cst_pkg::ChCr || c == cst_pkg::ChLf);
    return c;
  endfunction

  function automatic logic [cst_pkg::ByteW-1:0] blank_byte();
    return $urandom_range(1, 0) ? cst_pkg::ChSpace : cst_pkg::ChTab;
  endfunction

  task automatic push_byte(input logic [cst_pkg::ByteW-1:0] c, input logic last);
    text_item_t it;
    it.ch   = c;
    it.last = last;
    text_q.insert(text_q.size(), it);
    n_sent++;
  endtask

  task automatic add_byte(input logic [cst_pkg::ByteW-1:0] c);
    push_byte(c, $urandom_range(15, 0) == 0);
  endtask

  task automatic add_blanks();
    if ($urandom_range(3, 0) == 0) begin
      repeat ($urandom_range(2, 1)) add_byte(blank_byte());
    end
  endtask

  // one record: fields with optional blanks, ended by CR, LF or CR LF
  task automatic add_record();
    int unsigned               nf;
    logic [cst_pkg::ByteW-1:0] c;
    nf = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(4, 1);
    for (int unsigned f = 0; f < nf; f++) begin
      if (f != 0) add_byte(cst_pkg::ChSemi);
      add_blanks();
      case ($urandom_range(2, 0))
        1: begin
          repeat ($urandom_range(6, 1)) add_byte(plain_byte());
        end
        2: begin
          add_byte(cst_pkg::ChQuote);
          repeat ($urandom_range(6, 0)) begin
            c = ($urandom_range(4, 0) == 0) ? cst_pkg::ChQuote :
                                              cst_pkg::ByteW'($urandom_range(255, 0));
            add_byte(c);
            if (c == cst_pkg::ChQuote) add_byte(cst_pkg::ChQuote);
          end
          add_byte(cst_pkg::ChQuote);
        end
        default: ;
      endcase
      add_blanks();
    end
    case ($urandom_range(2, 0))
      0: add_byte(cst_pkg::ChCr);
      1: add_byte(cst_pkg::ChLf);
      default: begin
        add_byte(cst_pkg::ChCr);
        add_byte(cst_pkg::ChLf);
      end
    endcase
  endtask

  task automatic add_records(input int unsigned count);
    int unsigned goal;
    goal = n_sent + count;
    while (n_sent < goal) add_record();
  endtask

  // stray byte that trips the sticky error state, then more bytes into it
  task automatic add_broken_tail();
    case ($urandom_range(2, 0))
      0: begin
        add_byte(plain_byte());
        add_byte(cst_pkg::ChQuote);
      end
      1: begin
        add_byte(cst_pkg::ChQuote);
        add_byte(plain_byte());
        add_byte(cst_pkg::ChQuote);
        add_byte(plain_byte());
      end
      default: begin
        add_byte(plain_byte());
        add_byte(blank_byte());
        add_byte(plain_byte());
      end
    endcase
    repeat (30) add_byte(cst_pkg::ByteW'($urandom_range(255, 0)));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (!drained) @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [cst_pkg::ByteW-1:0] exp_v,
                             input logic [cst_pkg::ByteW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $realtime, name, exp_v,
               act_v);
      n_errors++;
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    text_item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (!in_valid_i || in_taken) begin
        if (text_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
          it = text_q.pop_front();
          in_valid_i <= 1'b1;
          in_byte_i  <= it.ch;
          is_last_i  <= it.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99, 0) < idle_pct);
    end
  end

  // predictor and monitor
  always @(posedge clk_i) begin
    token_t exp_t;
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) token_q.insert(token_q.size(), tokenize_step(in_byte_i, is_last_i));
      if (out_valid_o && !out_stall_i) begin
        if (token_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, kind %0d byte 0x%0h",
                   $realtime, kind_o, field_byte_o);
          n_errors++;
        end else begin
          exp_t = token_q.pop_front();
          check_field("kind", cst_pkg::ByteW'(exp_t.kind), cst_pkg::ByteW'(kind_o));
          check_field("field_byte", exp_t.fbyte, field_byte_o);
          check_field("input_done", cst_pkg::ByteW'(exp_t.done),
                      cst_pkg::ByteW'(input_done_o));
          check_field("parse_ok", cst_pkg::ByteW'(exp_t.ok), cst_pkg::ByteW'(parse_ok_o));
          n_checked++;
          case (exp_t.kind)
            cst_pkg::KIND_BYTE: n_fbyte++;
            cst_pkg::KIND_FEND: n_fend++;
            cst_pkg::KIND_REND: n_rend++;
            cst_pkg::KIND_ERR:  n_err++;
            default: ;
          endcase
          if (exp_t.ok) n_clean++;
        end
      end
      drained = (text_q.size() == 0) && !in_valid_i && (token_q.size() == 0);
    end
  end

  initial begin
    // directed: byte extremes, quoting, line ends, unfinished text
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(cst_pkg::ChSemi, 1'b0);
    push_byte(cst_pkg::ChSpace, 1'b0);
    push_byte(cst_pkg::ChQuote, 1'b0);
    push_byte(cst_pkg::ChQuote, 1'b0);
    push_byte(cst_pkg::ChQuote, 1'b0);
    push_byte(cst_pkg::ChCr, 1'b0);
    push_byte(cst_pkg::ChQuote, 1'b0);
    push_byte(cst_pkg::ChTab, 1'b0);
    push_byte(cst_pkg::ChCr, 1'b0);
    push_byte(cst_pkg::ChLf, 1'b0);
    push_byte(cst_pkg::ChLf, 1'b0);
    push_byte(cst_pkg::ChCr, 1'b0);
    push_byte(8'h7A, 1'b0);
    push_byte(cst_pkg::ChSpace, 1'b0);
    push_byte(cst_pkg::ChLf, 1'b1);
    push_byte(cst_pkg::ChQuote, 1'b1);
    push_byte(cst_pkg::ChSemi, 1'b0);
    push_byte(cst_pkg::ChQuote, 1'b0);
    push_byte(cst_pkg::ChSemi, 1'b0);
    push_byte(cst_pkg::ChLf, 1'b1);
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    add_records(420);
    wait_drained();
    idle_pct = 0;
    add_records(420);
    wait_drained();
    idle_pct = 38;
    add_records(420);
    add_broken_tail();
    wait_drained();
    repeat (8) @(negedge clk_i);

    if (token_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime, token_q.size());
      n_errors++;
    end
    $display("checked %0d results from %0d bytes: %0d field bytes, %0d field ends,",
             n_checked, n_sent, n_fbyte, n_fend);
    $display("  %0d record ends, %0d error reports, %0d clean end-of-text reports",
             n_rend, n_err, n_clean);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
